>>> src/h2df_pkg.sv
package h2df_pkg;

  localparam logic [4:0]  PrefaceLen   = 5'd24;
  localparam logic [3:0]  HeaderLen    = 4'd9;
  localparam logic [7:0]  SettingsType = 8'h04;

  // Header byte positions: three length bytes, type, flags, then stream id.
  localparam logic [3:0]  HdrTypePos   = 4'd3;
  localparam logic [3:0]  HdrFlagsPos  = 4'd4;

  typedef enum logic [2:0] {
    PH_AWAIT      = 3'd0,
    PH_PREFACE    = 3'd1,
    PH_CLIENT_SET = 3'd2,
    PH_SETUP      = 3'd3,
    PH_SKIP       = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DROP    = 2'd0,
    KIND_PREFACE = 2'd1,
    KIND_HEADER  = 2'd2,
    KIND_PAYLOAD = 2'd3
  } kind_e;

  // Client connection preface "PRI * HTTP/2.0\r\n\r\nSM\r\n\r\n".
  function automatic logic [7:0] preface_byte(input logic [4:0] idx);
    logic [7:0] val;
    unique case (idx)
      5'd0:  val = 8'h50;
      5'd1:  val = 8'h52;
      5'd2:  val = 8'h49;
      5'd3:  val = 8'h20;
      5'd4:  val = 8'h2A;
      5'd5:  val = 8'h20;
      5'd6:  val = 8'h48;
      5'd7:  val = 8'h54;
      5'd8:  val = 8'h54;
      5'd9:  val = 8'h50;
      5'd10: val = 8'h2F;
      5'd11: val = 8'h32;
      5'd12: val = 8'h2E;
      5'd13: val = 8'h30;
      5'd14: val = 8'h0D;
      5'd15: val = 8'h0A;
      5'd16: val = 8'h0D;
      5'd17: val = 8'h0A;
      5'd18: val = 8'h53;
      5'd19: val = 8'h4D;
      5'd20: val = 8'h0D;
      5'd21: val = 8'h0A;
      5'd22: val = 8'h0D;
      5'd23: val = 8'h0A;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

>>> src/h2df_if.sv
interface h2df_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       from_server;
  logic       packet_end;

  modport source (output valid, output data_byte, output from_server, output packet_end,
                  input ready);
  modport sink (input valid, input data_byte, input from_server, input packet_end,
                output ready);
endinterface

interface h2df_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  byte_kind;
  logic        frame_dir;
  logic [7:0]  frm_type;
  logic [7:0]  frame_flags;
  logic [31:0] stream_ident;
  logic [23:0] frame_length;
  logic [7:0]  data_out;
  logic        frame_start;
  logic        frame_end;
  logic [2:0]  flow_phase;
  logic        error_now;

  modport source (output valid, output byte_kind, output frame_dir, output frm_type,
                  output frame_flags, output stream_ident, output frame_length,
                  output data_out, output frame_start, output frame_end,
                  output flow_phase, output error_now, input ready);
  modport sink (input valid, input byte_kind, input frame_dir, input frm_type,
                input frame_flags, input stream_ident, input frame_length,
                input data_out, input frame_start, input frame_end,
                input flow_phase, input error_now, output ready);
endinterface

>>> src/http2_connection_deframer_top.sv
// Channel | Dir | Payload                                         | Handshake
// in_i    | in  | data_byte, from_server, packet_end              | valid/ready
// out_o   | out | byte_kind, frame_dir, frm_type, frame_flags,    | valid/ready
//         |     | stream_ident, frame_length, data_out,           |
//         |     | frame_start, frame_end, flow_phase, error_now   |
//
// One item per clock while out_o does not stall; each taken item passes through the input
// register, then one pass of the flow logic into the result register.
// The per-direction header/payload counters set the combinational update path.
// Reset (rst_ni low, asynchronous) returns the flow to awaiting the preface.
// A stall on out_o holds the result register, and the input register once it holds an item.
module http2_connection_deframer_top (
  input logic        clk_i,
  input logic        rst_ni,
  h2df_in_if.sink    in_i,
  h2df_out_if.source out_o
);

  // Input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_dir_q;
  logic       s1_end_q;

  // Flow state
  h2df_pkg::phase_e phase_q, phase_d;
  logic [4:0]  pref_cnt_q, pref_cnt_d;
  logic [3:0]  hc_q      [2];
  logic [3:0]  hc_d      [2];
  logic [23:0] len_q     [2];
  logic [23:0] len_d     [2];
  logic [7:0]  type_q    [2];
  logic [7:0]  type_d    [2];
  logic [7:0]  flags_q   [2];
  logic [7:0]  flags_d   [2];
  logic [31:0] stream_q  [2];
  logic [31:0] stream_d  [2];
  logic [23:0] left_q    [2];
  logic [23:0] left_d    [2];

  // Result register
  logic        out_valid_q;
  h2df_pkg::kind_e kind_q;
  logic        dir_q;
  logic [7:0]  ftype_q;
  logic [7:0]  fflags_q;
  logic [31:0] fstream_q;
  logic [23:0] flen_q;
  logic [7:0]  data_q;
  logic        fs_q;
  logic        fe_q;
  logic [2:0]  fphase_q;
  logic        err_q;

  logic advance;

  // Combinational results of the current item
  h2df_pkg::kind_e kind;
  logic        err;
  logic        fs;
  logic        fe;
  logic        check;
  logic [3:0]  hc;
  logic [3:0]  hc_n;
  logic [23:0] base_len;
  logic [7:0]  base_type;
  logic [7:0]  base_flags;
  logic [31:0] base_stream;
  logic [23:0] left_n;

  // Move the input register forward whenever the result register is free or draining.
  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.data_byte;
      s1_dir_q  <= in_i.from_server;
      s1_end_q  <= in_i.packet_end;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    pref_cnt_d = pref_cnt_q;
    hc_d       = hc_q;
    len_d      = len_q;
    type_d     = type_q;
    flags_d    = flags_q;
    stream_d   = stream_q;
    left_d     = left_q;
    kind       = h2df_pkg::KIND_DROP;
    err        = 1'b0;
    fs         = 1'b0;
    fe         = 1'b0;
    check      = 1'b0;
    hc         = hc_q[s1_dir_q];
    hc_n       = hc;
    left_n     = left_q[s1_dir_q];
    // A new header starts from cleared fields.
    base_len    = (hc == 4'd0) ? 24'd0 : len_q[s1_dir_q];
    base_type   = (hc == 4'd0) ? 8'd0  : type_q[s1_dir_q];
    base_flags  = (hc == 4'd0) ? 8'd0  : flags_q[s1_dir_q];
    base_stream = (hc == 4'd0) ? 32'd0 : stream_q[s1_dir_q];

    unique case (phase_q) inside
      h2df_pkg::PH_AWAIT: begin
        if (s1_dir_q) begin
          // Server bytes are dropped, and raise an error if they cut into a started preface.
          err = (pref_cnt_q != 5'd0);
        end else if (pref_cnt_q >= h2df_pkg::PrefaceLen ||
                     s1_byte_q != h2df_pkg::preface_byte(pref_cnt_q)) begin
          err = 1'b1;
        end else begin
          pref_cnt_d = pref_cnt_q + 5'd1;
          if (pref_cnt_d == h2df_pkg::PrefaceLen) begin
            phase_d = h2df_pkg::PH_PREFACE;
          end else if (s1_end_q) begin
            err = 1'b1;
          end
          if (!err) begin
            kind = h2df_pkg::KIND_PREFACE;
          end
        end
      end
      h2df_pkg::PH_PREFACE, h2df_pkg::PH_CLIENT_SET, h2df_pkg::PH_SETUP: begin
        // The first client frame, then the first server frame, must be SETTINGS.
        check = (phase_q == h2df_pkg::PH_PREFACE && !s1_dir_q) ||
                (phase_q == h2df_pkg::PH_CLIENT_SET && s1_dir_q);
        if (phase_q == h2df_pkg::PH_PREFACE && s1_dir_q) begin
          err = 1'b1;
        end else if (hc < h2df_pkg::HeaderLen) begin
          len_d[s1_dir_q]    = base_len;
          type_d[s1_dir_q]   = base_type;
          flags_d[s1_dir_q]  = base_flags;
          stream_d[s1_dir_q] = base_stream;
          if (hc < h2df_pkg::HdrTypePos) begin
            len_d[s1_dir_q] = {base_len[15:0], s1_byte_q};
          end else if (hc == h2df_pkg::HdrTypePos) begin
            type_d[s1_dir_q] = s1_byte_q;
          end else if (hc == h2df_pkg::HdrFlagsPos) begin
            flags_d[s1_dir_q] = s1_byte_q;
          end else begin
            stream_d[s1_dir_q] = {base_stream[23:0], s1_byte_q};
          end

          if (check && hc == h2df_pkg::HdrTypePos && s1_byte_q != h2df_pkg::SettingsType) begin
            err = 1'b1;
          end else if (hc < h2df_pkg::HeaderLen - 4'd1 && s1_end_q) begin
            // A header may not be split across packets.
            err = 1'b1;
          end

          if (!err) begin
            kind = h2df_pkg::KIND_HEADER;
            if (check && hc == h2df_pkg::HdrTypePos) begin
              phase_d = (phase_q == h2df_pkg::PH_PREFACE) ? h2df_pkg::PH_CLIENT_SET
                                                          : h2df_pkg::PH_SETUP;
            end
            hc_n = hc + 4'd1;
            if (hc_n == h2df_pkg::HeaderLen) begin
              fs = 1'b1;
              left_d[s1_dir_q] = len_d[s1_dir_q];
              if (len_d[s1_dir_q] == 24'd0) begin
                fe   = 1'b1;
                hc_n = 4'd0;
              end
            end
            hc_d[s1_dir_q] = hc_n;
          end
        end else begin
          // Payload: count down, close the frame at zero.
          kind = h2df_pkg::KIND_PAYLOAD;
          if (left_n != 24'd0) begin
            left_n = left_n - 24'd1;
          end
          left_d[s1_dir_q] = left_n;
          if (left_n == 24'd0) begin
            fe = 1'b1;
            hc_d[s1_dir_q] = 4'd0;
          end
        end
      end
      default: begin
        // Skipping: drop everything.
        phase_d = h2df_pkg::PH_SKIP;
      end
    endcase

    if (err) begin
      phase_d = h2df_pkg::PH_SKIP;
      kind    = h2df_pkg::KIND_DROP;
      fs      = 1'b0;
      fe      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= h2df_pkg::PH_AWAIT;
      pref_cnt_q <= 5'd0;
      for (int i = 0; i < 2; i++) begin
        hc_q[i]     <= 4'd0;
        len_q[i]    <= 24'd0;
        type_q[i]   <= 8'd0;
        flags_q[i]  <= 8'd0;
        stream_q[i] <= 32'd0;
        left_q[i]   <= 24'd0;
      end
    end else if (advance) begin
      phase_q    <= phase_d;
      pref_cnt_q <= pref_cnt_d;
      hc_q       <= hc_d;
      len_q      <= len_d;
      type_q     <= type_d;
      flags_q    <= flags_d;
      stream_q   <= stream_d;
      left_q     <= left_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // Header fields show the direction's registers after this item, only for frame bytes.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind_q   <= kind;
      data_q   <= s1_byte_q;
      fs_q     <= fs;
      fe_q     <= fe;
      fphase_q <= 3'(phase_d);
      err_q    <= err;
      if (kind == h2df_pkg::KIND_HEADER || kind == h2df_pkg::KIND_PAYLOAD) begin
        dir_q     <= s1_dir_q;
        ftype_q   <= type_d[s1_dir_q];
        fflags_q  <= flags_d[s1_dir_q];
        fstream_q <= stream_d[s1_dir_q];
        flen_q    <= len_d[s1_dir_q];
      end else begin
        dir_q     <= 1'b0;
        ftype_q   <= 8'd0;
        fflags_q  <= 8'd0;
        fstream_q <= 32'd0;
        flen_q    <= 24'd0;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.byte_kind    = 2'(kind_q);
  assign out_o.frame_dir    = dir_q;
  assign out_o.frm_type     = ftype_q;
  assign out_o.frame_flags  = fflags_q;
  assign out_o.stream_ident = fstream_q;
  assign out_o.frame_length = flen_q;
  assign out_o.data_out     = data_q;
  assign out_o.frame_start  = fs_q;
  assign out_o.frame_end    = fe_q;
  assign out_o.flow_phase   = fphase_q;
  assign out_o.error_now    = err_q;

  // Skipping is left only by reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == h2df_pkg::PH_SKIP |=> phase_q == h2df_pkg::PH_SKIP)
    else $error("flow left skipping phase");

  // An erroring item is dropped and reports the skipping phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && err_q |-> kind_q == h2df_pkg::KIND_DROP &&
                             fphase_q == 3'(h2df_pkg::PH_SKIP) && !fs_q && !fe_q)
    else $error("error item not dropped");

  // A frame start is always the last header byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && fs_q |-> kind_q == h2df_pkg::KIND_HEADER)
    else $error("frame start on non-header byte");

  // A header byte that ends a frame must also start it (zero-length frame).
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && fe_q && kind_q == h2df_pkg::KIND_HEADER |-> fs_q && flen_q == 24'd0)
    else $error("header byte ended non-empty frame");

endmodule
